/* rtl/core/spmv_pkg.sv */
package spmv_pkg;

  localparam int VECTOR_DEPTH_DEF = 4096;
  localparam int ROW_BITS_DEF     = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam int INDEX_W   = 12;
  localparam int VALUE_W   = 32;
  localparam int SUM_W     = 48;
  localparam int ROW_OUT_W = 16;
  localparam int CFG_W     = 16;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_MAC   = 2'd1;
  localparam logic [1:0] MODE_EMPTY = 2'd2;

  localparam logic signed [SUM_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MAC,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic                       last;
    logic                       addr_ok;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } back_status_t;

endpackage

/* rtl/core/spmv_ram.sv */
module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        addr,
  input  logic [WIDTH-1:0]                wdata,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/spmv_front.sv */
module spmv_front #(
  parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [1:0]                           in_mode,
  input  logic [spmv_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [spmv_pkg::VALUE_W-1:0]  in_value,
  input  logic                                 in_row_last,
  output logic                                 push,
  output spmv_pkg::item_t                      item
);

  logic keep;

  always_comb begin
    keep         = 1'b1;
    item.op      = spmv_pkg::OP_LOAD;
    item.last    = 1'b0;
    item.addr_ok = (32'(in_index) < 32'(VECTOR_DEPTH));
    item.index   = in_index;
    item.value   = in_value;
    case (in_mode)
      spmv_pkg::MODE_LOAD: begin
        item.op = spmv_pkg::OP_LOAD;
      end
      spmv_pkg::MODE_MAC: begin
        item.op   = spmv_pkg::OP_MAC;
        item.last = in_row_last;
      end
      spmv_pkg::MODE_EMPTY: begin
        item.op = spmv_pkg::OP_CLOSE;
      end
      default: begin
        // drop unused mode
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && in_ready && keep;

endmodule

/* rtl/core/spmv_queue.sv */
module spmv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = spmv_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/spmv_back.sv */
module spmv_back #(
  parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF,
  parameter int ROW_BITS     = spmv_pkg::ROW_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  input  spmv_pkg::item_t                        q_item,
  output logic                                   q_pop,
  input  logic                                   cfg_we,
  input  logic [spmv_pkg::CFG_W-1:0]             cfg_start_row,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [spmv_pkg::ROW_OUT_W-1:0]         out_row_index,
  output logic signed [spmv_pkg::SUM_W-1:0]      out_row_sum,
  output logic                                   out_saturated,
  output spmv_pkg::back_status_t                 status
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic adv;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [spmv_pkg::VALUE_W-1:0] ram_rdata;

  // stage 1: vector read
  logic                                 s1_valid_r, s1_valid_nxt;
  spmv_pkg::op_t                        s1_op_r;
  logic                                 s1_last_r, s1_ok_r;
  logic signed [spmv_pkg::VALUE_W-1:0]  s1_value_r;

  // stage 2: product
  logic                                 s2_valid_r, s2_valid_nxt;
  spmv_pkg::op_t                        s2_op_r;
  logic                                 s2_last_r;
  logic signed [spmv_pkg::SUM_W-1:0]    s2_prod_r;
  logic signed [spmv_pkg::VALUE_W-1:0]  x_sel;
  logic signed [2*spmv_pkg::VALUE_W-1:0] mul_full;

  // stage 3: accumulate and result register
  logic signed [spmv_pkg::SUM_W-1:0]    acc_r, acc_nxt;
  logic                                 satf_r, satf_nxt;
  logic [ROW_BITS-1:0]                  cnt_r, cnt_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [spmv_pkg::ROW_OUT_W-1:0]       out_idx_r, out_idx_nxt;
  logic signed [spmv_pkg::SUM_W-1:0]    out_sum_r, out_sum_nxt;
  logic                                 out_sat_r, out_sat_nxt;
  logic signed [spmv_pkg::SUM_W:0]      sum_ext;
  logic                                 ovf;
  logic signed [spmv_pkg::SUM_W-1:0]    sat_sum;

  assign adv      = !out_valid_r || out_ready;
  assign q_pop    = adv && q_valid;
  assign ram_addr = AW'(q_item.index);
  assign ram_we   = q_pop && (q_item.op == spmv_pkg::OP_LOAD) && q_item.addr_ok;
  assign ram_re   = q_pop && (q_item.op == spmv_pkg::OP_MAC) && q_item.addr_ok;

  spmv_ram #(
    .WIDTH (spmv_pkg::VALUE_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (q_item.value),
    .rdata (ram_rdata)
  );

  assign s1_valid_nxt = adv ? (q_pop && (q_item.op != spmv_pkg::OP_LOAD)) : s1_valid_r;
  assign s2_valid_nxt = adv ? s1_valid_r : s2_valid_r;

  assign x_sel    = s1_ok_r ? $signed(ram_rdata) : '0;
  assign mul_full = s1_value_r * x_sel;

  assign sum_ext = {acc_r[spmv_pkg::SUM_W-1], acc_r}
                 + {s2_prod_r[spmv_pkg::SUM_W-1], s2_prod_r};
  assign ovf     = sum_ext[spmv_pkg::SUM_W] ^ sum_ext[spmv_pkg::SUM_W-1];
  assign sat_sum = ovf ? (sum_ext[spmv_pkg::SUM_W] ? spmv_pkg::ACC_MIN : spmv_pkg::ACC_MAX)
                       : sum_ext[spmv_pkg::SUM_W-1:0];

  always_comb begin
    acc_nxt       = acc_r;
    satf_nxt      = satf_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_sum_nxt   = out_sum_r;
    out_sat_nxt   = out_sat_r;
    if (adv && s2_valid_r) begin
      case (s2_op_r)
        spmv_pkg::OP_MAC: begin
          acc_nxt  = sat_sum;
          satf_nxt = satf_r | ovf;
          if (s2_last_r) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = spmv_pkg::ROW_OUT_W'(cnt_r);
            out_sum_nxt   = sat_sum;
            out_sat_nxt   = satf_r | ovf;
            acc_nxt       = '0;
            satf_nxt      = 1'b0;
            cnt_nxt       = cnt_r + 1'b1;
          end
        end
        spmv_pkg::OP_CLOSE: begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = spmv_pkg::ROW_OUT_W'(cnt_r);
          out_sum_nxt   = acc_r;
          out_sat_nxt   = satf_r;
          acc_nxt       = '0;
          satf_nxt      = 1'b0;
          cnt_nxt       = cnt_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cfg_we) begin
      cnt_nxt = ROW_BITS'(cfg_start_row);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      satf_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      satf_r      <= satf_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= q_item.op;
      s1_last_r  <= q_item.last;
      s1_ok_r    <= q_item.addr_ok;
      s1_value_r <= q_item.value;
      s2_op_r    <= s1_op_r;
      s2_last_r  <= s1_last_r;
      s2_prod_r  <= mul_full[2*spmv_pkg::VALUE_W-1:16];
    end
    out_idx_r <= out_idx_nxt;
    out_sum_r <= out_sum_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_idx_r;
  assign out_row_sum     = out_sum_r;
  assign out_saturated   = out_sat_r;
  assign status.s1_valid = s1_valid_r;
  assign status.s2_valid = s2_valid_r;

endmodule

/* rtl/core/csr_sparse_matrix_vector_multiply.sv */
// Path: a closing request passes the queue, the vector read stage, the multiply
// stage and the accumulate/result register, and waits there while the output stalls.
// Throughput: one request per cycle while the queue has room and the output is not
// stalled, set by the single vector RAM port and the saturating accumulate loop.
// Reset: synchronous, active-low rst_n clears queue, pipeline, accumulator,
// flag and row counter; the vector store holds no reset value.
module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF,
  parameter int ROW_BITS     = spmv_pkg::ROW_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_mode,
  input  logic [spmv_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [spmv_pkg::VALUE_W-1:0]  in_value,
  input  logic                                 in_row_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [spmv_pkg::ROW_OUT_W-1:0]       out_row_index,
  output logic signed [spmv_pkg::SUM_W-1:0]    out_row_sum,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [spmv_pkg::CFG_W-1:0]           cfg_start_row
);

  localparam int ITEM_W = $bits(spmv_pkg::item_t);

  logic                   q_push, q_pop, q_valid;
  spmv_pkg::item_t        f_item, q_item;
  logic [ITEM_W-1:0]      q_data;
  spmv_pkg::back_status_t b_status;

  spmv_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_index    (in_index),
    .in_value    (in_value),
    .in_row_last (in_row_last),
    .push        (q_push),
    .item        (f_item)
  );

  spmv_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (spmv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (f_item),
    .not_full  (in_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  assign q_item = spmv_pkg::item_t'(q_data);

  spmv_back #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .ROW_BITS     (ROW_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .cfg_we        (cfg_we),
    .cfg_start_row (cfg_start_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_row_sum   (out_row_sum),
    .out_saturated (out_saturated),
    .status        (b_status)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(b_status.s2_valid))
    else $error("result raised without a request in the accumulate stage");

  a_load_classified: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == spmv_pkg::MODE_LOAD))
      |-> (q_push && (f_item.op == spmv_pkg::OP_LOAD)))
    else $error("vector load request not queued as a load");

  a_pipe_fed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(b_status.s2_valid) |-> $past(b_status.s1_valid))
    else $error("product stage filled without a read stage request");

endmodule
